[design/hrr_pkg.sv]
package hrr_pkg;

  // Number of entries in the history ring.
  localparam int unsigned DEPTH = 64;
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EntryW = 16;
  localparam logic [AddrW-1:0] LastIdx = AddrW'(DEPTH - 1);

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_e;

  typedef enum logic {
    ACT_BACK = 1'b0,
    ACT_STOP = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    MODE_REC  = 2'b01,
    MODE_PLAY = 2'b10
  } mode_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] speed_now;
    logic [7:0] steer_now;
  } in_req_t;

  typedef struct packed {
    logic       action;
    logic [7:0] speed_out;
    logic [7:0] steer_out;
  } out_rsp_t;

  // Access that the controller places on the history memory in one cycle.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [AddrW-1:0]  waddr;
    logic [AddrW-1:0]  raddr;
    logic [EntryW-1:0] wdata;
  } mem_req_t;

endpackage

[design/hrr_ram.sv]
module hrr_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/hrr_ctrl.sv]
module hrr_ctrl import hrr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  in_req_t  req_i,
  output mem_req_t mem_o,
  output logic     stop_o
);

  mode_e            mode_q, mode_d;
  logic [AddrW-1:0] wr_idx_q, wr_idx_d;
  logic             wrapped_q, wrapped_d;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic             rd_live_q, rd_live_d;
  logic [AddrW-1:0] start_q, start_d;
  logic [AddrW-1:0] upper_q, upper_d;

  always_comb begin
    mode_d    = mode_q;
    wr_idx_d  = wr_idx_q;
    wrapped_d = wrapped_q;
    rd_idx_d  = rd_idx_q;
    rd_live_d = rd_live_q;
    start_d   = start_q;
    upper_d   = upper_q;
    mem_o     = '0;
    stop_o    = 1'b0;
    if (step_i) begin
      unique case (mode_q)
        MODE_REC: begin
          if (req_i.cmd == CMD_START) begin
            start_d   = wr_idx_q;
            rd_live_d = (wr_idx_q != '0);
            rd_idx_d  = wr_idx_q - AddrW'(1);
            mode_d    = MODE_PLAY;
          end else begin
            mem_o.we    = 1'b1;
            mem_o.waddr = wr_idx_q;
            mem_o.wdata = {req_i.speed_now, req_i.steer_now};
            if (wr_idx_q == LastIdx) begin
              wr_idx_d  = '0;
              wrapped_d = 1'b1;
            end else begin
              wr_idx_d = wr_idx_q + AddrW'(1);
            end
          end
        end
        MODE_PLAY: begin
          if (req_i.cmd == CMD_TICK) begin
            priority if (rd_live_q) begin
              // First phase: newest entry down to entry zero.
              mem_o.re    = 1'b1;
              mem_o.raddr = rd_idx_q;
              if (rd_idx_q == '0) begin
                rd_live_d = 1'b0;
              end else begin
                rd_idx_d = rd_idx_q - AddrW'(1);
              end
            end else if (wrapped_q && (upper_q > start_q)) begin
              // Second phase: top entry down to just above the start.
              mem_o.re    = 1'b1;
              mem_o.raddr = upper_q;
              upper_d     = upper_q - AddrW'(1);
            end else begin
              stop_o    = 1'b1;
              wr_idx_d  = '0;
              wrapped_d = 1'b0;
              upper_d   = LastIdx;
              mode_d    = MODE_REC;
            end
          end
        end
        default: begin
          mode_d = MODE_REC;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_REC;
      wr_idx_q  <= '0;
      wrapped_q <= 1'b0;
      rd_idx_q  <= '0;
      rd_live_q <= 1'b0;
      start_q   <= '0;
      upper_q   <= LastIdx;
    end else begin
      mode_q    <= mode_d;
      wr_idx_q  <= wr_idx_d;
      wrapped_q <= wrapped_d;
      rd_idx_q  <= rd_idx_d;
      rd_live_q <= rd_live_d;
      start_q   <= start_d;
      upper_q   <= upper_d;
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_o.we && mem_o.re))
    else $error("history memory read and written in one cycle");

  a_rec_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_REC) |-> !mem_o.re)
    else $error("history read while recording");

  a_rec_upper_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_REC) |-> (upper_q == LastIdx))
    else $error("wrapped-phase index not at top entry while recording");

  a_stop_back_to_rec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_o |=> (mode_q == MODE_REC) && (wr_idx_q == '0) && !wrapped_q)
    else $error("stop did not return to a cleared recording state");

endmodule

[design/history_record_reverse_replay.sv]
// Reverse-replay history ring.
//
// The input channel (in_valid_i / in_ready_o / in_req_i) carries one request
// per timer tick. While recording, a tick stores its speed and steering pair
// in a ring memory and gives no result; a start command arms replay. While
// replaying, each tick returns one stored pair, newest first, on the output
// channel (out_valid_o / out_ready_i / out_rsp_o), and the tick after the
// last pair returns a stop result and goes back to recording.
//
// A recording tick or a start command completes in the cycle it is accepted.
// A replay tick reads through the single read port of the history memory,
// whose read data is registered and then loaded into the output register.
// A stop result is loaded into the output register in the cycle it is
// accepted. The output register separates the two sides: a new request is
// taken in the same cycle the waiting result is taken by the receiver.
// While the receiver stalls with a result held, no request is accepted.
//
// Reset clears the mode, indices and wrap mark; the memory itself is not
// cleared, since replay only ever reads entries that were written.
module history_record_reverse_replay import hrr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  mem_req_t          mem_req;
  logic              stop;
  logic              step;
  logic [EntryW-1:0] rdata;

  logic     pend_q, pend_d;
  logic     out_valid_q, out_valid_d;
  out_rsp_t out_rsp_q, out_rsp_d;

  // Accept only when no read is in flight and the output register will be
  // free in the next cycle.
  assign in_ready_o = !pend_q && (!out_valid_q || out_ready_i);
  assign step       = in_valid_i && in_ready_o;

  hrr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (in_req_i),
    .mem_o  (mem_req),
    .stop_o (stop)
  );

  hrr_ram #(
    .Depth (DEPTH),
    .Width (EntryW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    pend_d      = mem_req.re;
    out_valid_d = out_valid_q;
    out_rsp_d   = out_rsp_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    priority if (pend_q) begin
      out_valid_d         = 1'b1;
      out_rsp_d.action    = ACT_BACK;
      out_rsp_d.speed_out = rdata[15:8];
      out_rsp_d.steer_out = rdata[7:0];
    end else if (stop) begin
      out_valid_d         = 1'b1;
      out_rsp_d.action    = ACT_STOP;
      out_rsp_d.speed_out = '0;
      out_rsp_d.steer_out = '0;
    end else begin
      out_rsp_d = out_rsp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_pend_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !out_valid_q)
    else $error("read data returned while output register still full");

  a_pend_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_ready_o)
    else $error("request accepted while a read is in flight");

  a_read_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.re |=> ##1 out_valid_q)
    else $error("replay read did not produce a result");

endmodule
